/* rtl/pe_pkg.sv */
// ----------------------------------------------------------------------------
// pe_pkg
// Shared types and constants of the particle Euler step block.
// ----------------------------------------------------------------------------
`default_nettype none

package pe_pkg;

  localparam int unsigned ARENA_SIZE = 500;

  localparam logic [31:0] ARENA_Q16    = 32'(ARENA_SIZE * 65536);
  localparam logic [31:0] LIM_Q16      = 32'd32768000;
  localparam logic [63:0] LIM_SQ       = 64'd1073741824000000;
  localparam logic [19:0] GRAVITY_Q16  = 20'd642908;
  localparam logic [31:0] WIND_Q16     = 32'd655360;
  localparam logic [31:0] LIFT_Q16     = 32'd3276800;
  // drag divisor 200 * 2^16: shift by 19, then scale by the reciprocal of 25
  localparam logic [30:0] DRAG_RECIP   = 31'd1374389535;
  localparam logic [31:0] POS_RESET    = 32'd16384000;
  localparam logic [22:0] MASS_RESET   = 23'd65536;
  localparam logic [23:0] RADIUS_RESET = 24'd655360;

  typedef enum logic [2:0] {
    CFG_MASS    = 3'd0,
    CFG_RADIUS  = 3'd1,
    CFG_WIND    = 3'd2,
    CFG_LIFT    = 3'd3,
    CFG_DRAG    = 3'd4,
    CFG_START_X = 3'd5,
    CFG_START_Y = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WIND_NONE  = 2'd0,
    WIND_RIGHT = 2'd1,
    WIND_LEFT  = 2'd2
  } wind_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_BOUNCE,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_SUM,
    OP_SQRT_GO,
    OP_LMUL_X,
    OP_LMUL_Y,
    OP_DIV_LIM,
    OP_LSET_X,
    OP_LSET_Y,
    OP_DMUL_X,
    OP_DMUL_Y,
    OP_DIV_DRAG,
    OP_DSET_X,
    OP_DSET_Y,
    OP_GRAV,
    OP_FORCE,
    OP_IMUL_X,
    OP_IMUL_Y,
    OP_DIV_INT,
    OP_VUPD_X,
    OP_VUPD_Y,
    OP_PMUL_X,
    OP_PMUL_Y,
    OP_PUPD_X,
    OP_PUPD_Y,
    OP_LOAD_OUT
  } dp_op_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_BOUNCE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_SUM,
    S_CHECK,
    S_LSQRT_W,
    S_LMUL_X,
    S_LDIV_X,
    S_LWAIT_X,
    S_LMUL_Y,
    S_LDIV_Y,
    S_LWAIT_Y,
    S_DSQRT_W,
    S_DMUL_X,
    S_DDIV_X,
    S_DWAIT_X,
    S_DMUL_Y,
    S_DDIV_Y,
    S_DWAIT_Y,
    S_GRAV,
    S_FORCE,
    S_IMUL_X,
    S_IDIV_X,
    S_IWAIT_X,
    S_IMUL_Y,
    S_IDIV_Y,
    S_IWAIT_Y,
    S_PMUL_X,
    S_PUPD_X,
    S_PMUL_Y,
    S_PUPD_Y,
    S_DONE
  } state_t;

  typedef struct packed {
    logic over_lim;
    logic drag_en;
    logic sqrt_done;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/particle_euler_step_with_drag_core.sv */
// ----------------------------------------------------------------------------
// particle_euler_step_with_drag_core
// One explicit Euler tick of a bouncing particle with wind, lift and drag.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  in_time_step
//   out      output     out_valid/out_ready out_pos_x/y, out_vel_x/y
//   cfg      input      cfg_we             cfg_idx, cfg_wdata
//
// An item's processing time is set by the bit-serial divider and the
// iterative root, and grows when speed limiting or drag runs.
// Synchronous reset loads the fixed centre position and zero velocity.
// The next item is taken while a result waits in the output register; a
// finished step holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_euler_step_with_drag_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [24:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y
);
  import pe_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  pe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  pe_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_time_step (in_time_step),
    .op           (op),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_vel_x    (out_vel_x),
    .out_vel_y    (out_vel_y)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_LOAD_OUT |=> out_valid)
    else $error("result load did not raise out_valid");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> !status.sqrt_done)
    else $error("root and divide finished together");

endmodule

`default_nettype wire

/* rtl/pe_sqrt.sv */
// ----------------------------------------------------------------------------
// pe_sqrt
// Iterative integer square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] n,
  output logic [31:0] res,
  output logic        done
);
  import pe_pkg::*;

  logic [63:0] n_r, res_r, bit_r;
  logic [63:0] n_nxt, res_nxt, sum;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;

  always_comb begin
    sum = res_r + bit_r;
    if (n_r >= sum) begin
      n_nxt   = n_r - sum;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      n_nxt   = n_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n;
      res_r <= 64'd0;
      bit_r <= 64'h4000_0000_0000_0000;
      cnt_r <= 5'd0;
    end else if (busy_r) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign res  = res_r[31:0];
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/pe_div.sv */
// ----------------------------------------------------------------------------
// pe_div
// Bit-serial signed 64 by unsigned 32 divider, quotient truncated to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [31:0]        divisor,
  output logic signed [63:0] quot,
  output logic               done
);
  import pe_pkg::*;

  logic [63:0] num_r, num_nxt;
  logic [31:0] den_r, rem_r, rem_nxt;
  logic [32:0] rem_sh;
  logic        neg_r, ge;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;

  always_comb begin
    rem_sh  = {rem_r, num_r[63]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
    num_nxt = {num_r[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[63];
      num_r <= dividend[63] ? (~dividend + 64'd1) : dividend;
      den_r <= divisor;
      rem_r <= 32'd0;
      cnt_r <= 6'd0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign quot = neg_r ? -$signed(num_r) : $signed(num_r);
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/pe_datapath.sv */
// ----------------------------------------------------------------------------
// pe_datapath
// Particle state, configuration, shared multiplier, root and divide units.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [24:0]         cfg_wdata,
  input  logic [15:0]         in_time_step,
  input  pe_pkg::dp_op_t      op,
  output pe_pkg::dp_status_t  status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_vel_x,
  output logic signed [31:0]  out_vel_y
);
  import pe_pkg::*;

  localparam logic signed [64:0] S_MAX = 65'sd2147483647;
  localparam logic signed [64:0] S_MIN = -65'sd2147483648;

  logic [22:0]        mass_r, mass_eff;
  logic [23:0]        radius_r;
  logic [1:0]         wind_r;
  logic               lift_r, drag_r;
  logic [15:0]        dt_r;
  logic signed [31:0] px_r, py_r, vx_r, vy_r;
  logic [63:0]        s_r;
  logic signed [63:0] prod_r;
  logic signed [33:0] dqx_r, dqy_r, fx_r, fy_r;
  logic [30:0]        dsh_r;
  logic               dneg_r;
  logic               out_valid_r;
  logic signed [31:0] opx_r, opy_r, ovx_r, ovy_r;

  logic [31:0]        abs_x, abs_y, mag;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic [63:0]        bx, by;
  logic signed [63:0] grav, fx64, fy64, dp, div_num, quot;
  logic [63:0]        dabs;
  logic [26:0]        dq_mag;
  logic signed [33:0] dq;
  logic [31:0]        div_den;
  logic               div_start, sqrt_start, sqrt_done, div_done;

  function automatic logic signed [31:0] neg_sat(logic signed [31:0] v);
    return (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
  endfunction

  function automatic logic signed [31:0] sat65(logic signed [64:0] x);
    logic signed [31:0] r;
    if (x > S_MAX) r = 32'sh7FFF_FFFF;
    else if (x < S_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [63:0] bounce(logic signed [31:0] p, logic signed [31:0] v,
                                         logic [23:0] r);
    logic signed [32:0] wmr, re;
    logic signed [31:0] pn, vn;
    wmr = $signed({1'b0, ARENA_Q16}) - $signed({9'b0, r});
    re  = $signed({9'b0, r});
    pn  = p;
    vn  = v;
    if ($signed({pn[31], pn}) > wmr) begin
      pn = wmr[31:0];
      vn = neg_sat(vn);
    end
    if ($signed({pn[31], pn}) < re) begin
      pn = re[31:0];
      vn = neg_sat(vn);
    end
    return {pn, vn};
  endfunction

  assign mass_eff = (mass_r == 23'd0) ? 23'd1 : mass_r;
  assign abs_x    = vx_r[31] ? (~vx_r + 32'd1) : vx_r;
  assign abs_y    = vy_r[31] ? (~vy_r + 32'd1) : vy_r;
  assign bx       = bounce(px_r, vx_r, radius_r);
  assign by       = bounce(py_r, vy_r, radius_r);

  always_comb begin
    case (op)
      OP_SQ_X: begin
        mul_a = $signed({2'b0, abs_x});
        mul_b = $signed({2'b0, abs_x});
      end
      OP_SQ_Y: begin
        mul_a = $signed({2'b0, abs_y});
        mul_b = $signed({2'b0, abs_y});
      end
      OP_LMUL_X: begin
        mul_a = {{2{vx_r[31]}}, vx_r};
        mul_b = $signed({2'b0, LIM_Q16});
      end
      OP_LMUL_Y: begin
        mul_a = {{2{vy_r[31]}}, vy_r};
        mul_b = $signed({2'b0, LIM_Q16});
      end
      OP_DMUL_X: begin
        mul_a = $signed({2'b0, mag});
        mul_b = {{2{vx_r[31]}}, vx_r};
      end
      OP_DMUL_Y: begin
        mul_a = $signed({2'b0, mag});
        mul_b = {{2{vy_r[31]}}, vy_r};
      end
      OP_DSET_X, OP_DSET_Y: begin
        mul_a = $signed({3'b0, dsh_r});
        mul_b = $signed({3'b0, DRAG_RECIP});
      end
      OP_GRAV: begin
        mul_a = $signed({11'b0, mass_eff});
        mul_b = $signed({14'b0, GRAVITY_Q16});
      end
      OP_IMUL_X: begin
        mul_a = fx_r;
        mul_b = $signed({18'b0, dt_r});
      end
      OP_IMUL_Y: begin
        mul_a = fy_r;
        mul_b = $signed({18'b0, dt_r});
      end
      OP_PMUL_X: begin
        mul_a = {{2{vx_r[31]}}, vx_r};
        mul_b = $signed({18'b0, dt_r});
      end
      OP_PMUL_Y: begin
        mul_a = {{2{vy_r[31]}}, vy_r};
        mul_b = $signed({18'b0, dt_r});
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign dq_mag = prod[61:35];
  assign dq     = dneg_r ? -$signed({7'b0, dq_mag}) : $signed({7'b0, dq_mag});

  always_comb begin
    grav = (prod_r + 64'sd32768) >>> 16;
    fy64 = grav - (lift_r ? $signed({32'b0, LIFT_Q16}) : 64'sd0)
         - {{30{dqy_r[33]}}, dqy_r};
    case (wind_t'(wind_r))
      WIND_NONE: fx64 = 64'sd0;
      WIND_LEFT: fx64 = -$signed({32'b0, WIND_Q16});
      default:   fx64 = $signed({32'b0, WIND_Q16});
    endcase
    fx64 = fx64 - {{30{dqx_r[33]}}, dqx_r};
    dp   = prod_r[63] ? ((prod_r + 64'sd131071) >>> 17) : (prod_r >>> 17);
    dabs = prod_r[63] ? (~prod_r + 64'd1) : prod_r;
  end

  always_comb begin
    div_start  = 1'b1;
    div_num    = prod_r;
    div_den    = mag;
    sqrt_start = (op == OP_SQRT_GO);
    case (op)
      OP_DIV_LIM:  div_den = mag;
      OP_DIV_INT: begin
        div_num = (prod_r <<< 5) + (prod_r <<< 4) + (prod_r <<< 1);
        div_den = {9'b0, mass_eff};
      end
      default:     div_start = 1'b0;
    endcase
  end

  pe_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n     (s_r),
    .res   (mag),
    .done  (sqrt_done)
  );

  pe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quot     (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r   <= MASS_RESET;
      radius_r <= RADIUS_RESET;
      wind_r   <= WIND_NONE;
      lift_r   <= 1'b0;
      drag_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_MASS:   mass_r   <= cfg_wdata[22:0];
        CFG_RADIUS: radius_r <= cfg_wdata[23:0];
        CFG_WIND:   wind_r   <= cfg_wdata[1:0];
        CFG_LIFT:   lift_r   <= cfg_wdata[0];
        CFG_DRAG:   drag_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= POS_RESET;
      py_r <= POS_RESET;
      vx_r <= 32'sd0;
      vy_r <= 32'sd0;
    end else begin
      case (op)
        OP_BOUNCE: begin
          px_r <= bx[63:32];
          vx_r <= bx[31:0];
          py_r <= by[63:32];
          vy_r <= by[31:0];
        end
        OP_LSET_X: vx_r <= quot[31:0];
        OP_LSET_Y: vy_r <= quot[31:0];
        OP_VUPD_X: vx_r <= sat65({{33{vx_r[31]}}, vx_r} + {quot[63], quot});
        OP_VUPD_Y: vy_r <= sat65({{33{vy_r[31]}}, vy_r} + {quot[63], quot});
        OP_PUPD_X: px_r <= sat65({{33{px_r[31]}}, px_r} + {dp[63], dp});
        OP_PUPD_Y: py_r <= sat65({{33{py_r[31]}}, py_r} + {dp[63], dp});
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        dt_r  <= in_time_step;
        dqx_r <= 34'sd0;
        dqy_r <= 34'sd0;
      end
      OP_SQ_X:   prod_r <= prod[63:0];
      OP_SQ_Y: begin
        prod_r <= prod[63:0];
        s_r    <= prod_r;
      end
      OP_SQ_SUM: s_r <= s_r + prod_r;
      OP_LMUL_X, OP_LMUL_Y, OP_DMUL_X, OP_DMUL_Y, OP_GRAV,
      OP_IMUL_X, OP_IMUL_Y, OP_PMUL_X, OP_PMUL_Y: prod_r <= prod[63:0];
      OP_DIV_DRAG: begin
        dneg_r <= prod_r[63];
        dsh_r  <= dabs[49:19];
      end
      OP_DSET_X: dqx_r <= dq;
      OP_DSET_Y: dqy_r <= dq;
      OP_FORCE: begin
        fx_r <= fx64[33:0];
        fy_r <= fy64[33:0];
      end
      OP_LOAD_OUT: begin
        opx_r <= px_r;
        opy_r <= py_r;
        ovx_r <= vx_r;
        ovy_r <= vy_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_LOAD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.over_lim  = s_r > LIM_SQ;
  assign status.drag_en   = drag_r;
  assign status.sqrt_done = sqrt_done;
  assign status.div_done  = div_done;
  assign status.out_busy  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_pos_x = opx_r;
  assign out_pos_y = opy_r;
  assign out_vel_x = ovx_r;
  assign out_vel_y = ovy_r;

endmodule

`default_nettype wire

/* rtl/pe_ctrl.sv */
// ----------------------------------------------------------------------------
// pe_ctrl
// Step sequencer: issues one datapath command per cycle unless waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pe_pkg::dp_status_t status,
  output pe_pkg::dp_op_t     op
);
  import pe_pkg::*;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_BOUNCE;
          pass_nxt  = 1'b0;
        end
      end
      S_BOUNCE: state_nxt = S_SQ_X;
      S_SQ_X:   state_nxt = S_SQ_Y;
      S_SQ_Y:   state_nxt = S_SQ_SUM;
      S_SQ_SUM: state_nxt = S_CHECK;
      S_CHECK: begin
        if (!pass_r && status.over_lim) state_nxt = S_LSQRT_W;
        else if (status.drag_en) state_nxt = S_DSQRT_W;
        else state_nxt = S_GRAV;
      end
      S_LSQRT_W: if (status.sqrt_done) state_nxt = S_LMUL_X;
      S_LMUL_X:  state_nxt = S_LDIV_X;
      S_LDIV_X:  state_nxt = S_LWAIT_X;
      S_LWAIT_X: if (status.div_done) state_nxt = S_LMUL_Y;
      S_LMUL_Y:  state_nxt = S_LDIV_Y;
      S_LDIV_Y:  state_nxt = S_LWAIT_Y;
      S_LWAIT_Y: begin
        if (status.div_done) begin
          state_nxt = S_SQ_X;
          pass_nxt  = 1'b1;
        end
      end
      S_DSQRT_W: if (status.sqrt_done) state_nxt = S_DMUL_X;
      S_DMUL_X:  state_nxt = S_DDIV_X;
      S_DDIV_X:  state_nxt = S_DWAIT_X;
      S_DWAIT_X: state_nxt = S_DMUL_Y;
      S_DMUL_Y:  state_nxt = S_DDIV_Y;
      S_DDIV_Y:  state_nxt = S_DWAIT_Y;
      S_DWAIT_Y: state_nxt = S_GRAV;
      S_GRAV:    state_nxt = S_FORCE;
      S_FORCE:   state_nxt = S_IMUL_X;
      S_IMUL_X:  state_nxt = S_IDIV_X;
      S_IDIV_X:  state_nxt = S_IWAIT_X;
      S_IWAIT_X: if (status.div_done) state_nxt = S_IMUL_Y;
      S_IMUL_Y:  state_nxt = S_IDIV_Y;
      S_IDIV_Y:  state_nxt = S_IWAIT_Y;
      S_IWAIT_Y: if (status.div_done) state_nxt = S_PMUL_X;
      S_PMUL_X:  state_nxt = S_PUPD_X;
      S_PUPD_X:  state_nxt = S_PMUL_Y;
      S_PMUL_Y:  state_nxt = S_PUPD_Y;
      S_PUPD_Y:  state_nxt = S_DONE;
      S_DONE:    if (!status.out_busy) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LATCH;
      end
      S_BOUNCE: op = OP_BOUNCE;
      S_SQ_X:   op = OP_SQ_X;
      S_SQ_Y:   op = OP_SQ_Y;
      S_SQ_SUM: op = OP_SQ_SUM;
      S_CHECK: begin
        if ((!pass_r && status.over_lim) || status.drag_en) op = OP_SQRT_GO;
      end
      S_LMUL_X:  op = OP_LMUL_X;
      S_LDIV_X:  op = OP_DIV_LIM;
      S_LWAIT_X: if (status.div_done) op = OP_LSET_X;
      S_LMUL_Y:  op = OP_LMUL_Y;
      S_LDIV_Y:  op = OP_DIV_LIM;
      S_LWAIT_Y: if (status.div_done) op = OP_LSET_Y;
      S_DMUL_X:  op = OP_DMUL_X;
      S_DDIV_X:  op = OP_DIV_DRAG;
      S_DWAIT_X: op = OP_DSET_X;
      S_DMUL_Y:  op = OP_DMUL_Y;
      S_DDIV_Y:  op = OP_DIV_DRAG;
      S_DWAIT_Y: op = OP_DSET_Y;
      S_GRAV:    op = OP_GRAV;
      S_FORCE:   op = OP_FORCE;
      S_IMUL_X:  op = OP_IMUL_X;
      S_IDIV_X:  op = OP_DIV_INT;
      S_IWAIT_X: if (status.div_done) op = OP_VUPD_X;
      S_IMUL_Y:  op = OP_IMUL_Y;
      S_IDIV_Y:  op = OP_DIV_INT;
      S_IWAIT_Y: if (status.div_done) op = OP_VUPD_Y;
      S_PMUL_X:  op = OP_PMUL_X;
      S_PUPD_X:  op = OP_PUPD_X;
      S_PMUL_Y:  op = OP_PMUL_Y;
      S_PUPD_Y:  op = OP_PUPD_Y;
      S_DONE:    if (!status.out_busy) op = OP_LOAD_OUT;
      default:   op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* dv/particle_euler_step_with_drag_core_test.sv */
// ----------------------------------------------------------------------------
// particle_euler_step_with_drag_core_test
// Drives time ticks through the particle step block and checks every result
// against a fixed-point predictor of bounce, speed limit, forces and
// integration, across several register settings and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_euler_step_with_drag_core_test;
  import pe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } particle_t;

  typedef struct {
    logic [15:0] dt;
    logic        known;
    particle_t   res;
  } tick_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_idx = '0;
  logic [24:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_time_step = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;

  particle_euler_step_with_drag_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state and registers
  logic [22:0] mass_q;
  logic [23:0] radius_q;
  logic [1:0]  wind_q;
  logic        lift_q, drag_q;
  logic [24:0] start_x_q, start_y_q;
  logic signed [31:0] px, py, vx, vy;

  particle_t   expected_q[$];
  int          fail_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned speed_sq(logic signed [31:0] a, logic signed [31:0] b);
    longint unsigned ua, ub;
    ua = a < 0 ? -longint'(a) : longint'(a);
    ub = b < 0 ? -longint'(b) : longint'(b);
    return ua * ua + ub * ub;
  endfunction

  task automatic wall_bounce(inout logic signed [31:0] p, inout logic signed [31:0] v);
    longint w, r;
    w = longint'(ARENA_SIZE) * 65536;
    r = longint'(radius_q);
    if (longint'(p) > w - r) begin
      p = sat32(w - r);
      v = sat32(-longint'(v));
    end
    if (longint'(p) < r) begin
      p = sat32(r);
      v = sat32(-longint'(v));
    end
  endtask

  task automatic step_particle(input logic [15:0] dt_in, output particle_t res);
    longint dt, lim, m, fx, fy, mag;
    longint unsigned s;
    dt = longint'(dt_in);
    lim = 500 * 65536;
    m = mass_q == 0 ? 1 : longint'(mass_q);
    fx = 0;
    wall_bounce(px, vx);
    wall_bounce(py, vy);
    s = speed_sq(vx, vy);
    if (s > longint'(lim) * longint'(lim)) begin
      mag = longint'(root64(s));
      vx = 32'((longint'(vx) * lim) / mag);
      vy = 32'((longint'(vy) * lim) / mag);
    end
    fy = (m * 642908 + 32768) / 65536;
    if (wind_q == WIND_RIGHT || wind_q == 2'd3) fx += 655360;
    else if (wind_q == WIND_LEFT) fx -= 655360;
    if (lift_q) fy -= 3276800;
    if (drag_q) begin
      mag = longint'(root64(speed_sq(vx, vy)));
      fx -= (mag * longint'(vx)) / 13107200;
      fy -= (mag * longint'(vy)) / 13107200;
    end
    vx = sat32(longint'(vx) + (fx * 50 * dt) / m);
    vy = sat32(longint'(vy) + (fy * 50 * dt) / m);
    px = sat32(longint'(px) + (longint'(vx) * dt) / 131072);
    py = sat32(longint'(py) + (longint'(vy) * dt) / 131072);
    res = '{px, py, vx, vy};
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [24:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MASS:    mass_q = val[22:0];
      CFG_RADIUS:  radius_q = val[23:0];
      CFG_WIND:    wind_q = val[1:0];
      CFG_LIFT:    lift_q = val[0];
      CFG_DRAG:    drag_q = val[0];
      CFG_START_X: start_x_q = val;
      CFG_START_Y: start_y_q = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_tick(input logic [15:0] dt, input logic known, input particle_t want);
    particle_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    step_particle(dt, res);
    if (known && res != want) begin
      $error("directed row dt=%0d: predictor %h vs table %h", dt, res, want);
      fail_cnt++;
    end
    expected_q.push_back(known ? want : res);
    in_valid <= 1'b1;
    in_time_step <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic random_ticks(input int n);
    logic [15:0] dt;
    repeat (n) begin
      case ($urandom_range(4))
        0: dt = $urandom_range(1) ? 16'hffff : 16'd0;
        1: dt = 16'($urandom_range(255));
        default: dt = 16'($urandom);
      endcase
      send_tick(dt, 1'b0, '0);
    end
  endtask

  task automatic random_setting(input bit extreme);
    write_reg(CFG_MASS, 25'(extreme ? ($urandom_range(1) ? 25'd6553600 : 25'd0)
                                    : ($urandom_range(3) == 0 ? $urandom_range(65535)
                                                              : $urandom_range(6553600))));
    write_reg(CFG_RADIUS, 25'(extreme ? ($urandom_range(1) ? 25'd16384000 : 25'd0)
                                      : $urandom_range(2000000)));
    write_reg(CFG_WIND, 25'($urandom_range(3)));
    write_reg(CFG_LIFT, 25'($urandom_range(1)));
    write_reg(CFG_DRAG, 25'($urandom_range(1)));
  endtask

  tick_row_t directed_rows[$];

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation waiting");
        fail_cnt++;
      end else begin
        particle_t e;
        e = expected_q.pop_front();
        if (out_pos_x !== e.pos_x) begin
          $error("pos_x expected %0d actual %0d", e.pos_x, out_pos_x); fail_cnt++;
        end
        if (out_pos_y !== e.pos_y) begin
          $error("pos_y expected %0d actual %0d", e.pos_y, out_pos_y); fail_cnt++;
        end
        if (out_vel_x !== e.vel_x) begin
          $error("vel_x expected %0d actual %0d", e.vel_x, out_vel_x); fail_cnt++;
        end
        if (out_vel_y !== e.vel_y) begin
          $error("vel_y expected %0d actual %0d", e.vel_y, out_vel_y); fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    particle_t z;
    mass_q = MASS_RESET;
    radius_q = RADIUS_RESET;
    wind_q = WIND_NONE;
    lift_q = 0;
    drag_q = 0;
    start_x_q = POS_RESET;
    start_y_q = POS_RESET;
    px = POS_RESET;
    py = POS_RESET;
    vx = 0;
    vy = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero tick after reset leaves the particle at rest in the center
    z = '{32'sd16384000, 32'sd16384000, 32'sd0, 32'sd0};
    directed_rows.push_back('{16'd0, 1'b1, z});
    directed_rows.push_back('{16'hffff, 1'b0, '0});
    directed_rows.push_back('{16'd1, 1'b0, '0});
    directed_rows.push_back('{16'h8000, 1'b0, '0});
    foreach (directed_rows[i])
      send_tick(directed_rows[i].dt, directed_rows[i].known, directed_rows[i].res);
    drain_results();

    // start registers move nothing now; zero mass, wind three, big radius
    write_reg(CFG_START_X, 25'd32768000);
    write_reg(CFG_START_Y, 25'd0);
    write_reg(CFG_MASS, 25'd0);
    write_reg(CFG_WIND, 25'd3);
    write_reg(CFG_RADIUS, 25'd16384000);
    for (int i = 0; i < 6; i++) send_tick(16'hffff, 1'b0, '0);
    drain_results();
    write_reg(CFG_MASS, 25'd6553600);
    write_reg(CFG_RADIUS, 25'd0);
    write_reg(CFG_WIND, 25'(WIND_LEFT));
    write_reg(CFG_LIFT, 25'd1);
    write_reg(CFG_DRAG, 25'd1);
    for (int i = 0; i < 6; i++) send_tick(16'hffff, 1'b0, '0);
    drain_results();
    write_reg(CFG_MASS, 25'd1);
    write_reg(CFG_RADIUS, 25'd655360);
    write_reg(CFG_WIND, 25'(WIND_RIGHT));
    write_reg(CFG_LIFT, 25'd0);
    for (int i = 0; i < 6; i++) send_tick(16'hffff, 1'b0, '0);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      random_setting(ph == 0 || ph == 5);
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
          random_ticks(20);
        join
      end
      random_ticks(126);
      drain_results();
    end

    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/pe_pkg.sv
rtl/pe_sqrt.sv
rtl/pe_div.sv
rtl/pe_datapath.sv
rtl/pe_ctrl.sv
rtl/particle_euler_step_with_drag_core.sv
dv/particle_euler_step_with_drag_core_test.sv
